### hw/rtl/ctk_pkg.sv
// Shared widths, constants and types for the two-link arm Coriolis block.
package ctk_pkg;

  // Field widths
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned VEL_W   = 16;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned SINE_W  = 16;
  localparam int unsigned OUT_W   = 32;

  // Sine datapath widths: folded magnitude, x squared, Horner term, products
  localparam int unsigned MAG_W   = 14;
  localparam int unsigned X2_W    = 2 * MAG_W + 4;
  localparam int unsigned T_W     = 31;
  localparam int unsigned P_W     = 32;
  localparam int unsigned RECIP_W = 33;
  localparam int unsigned PROD_W  = P_W + RECIP_W;

  // Fixed-point positions
  localparam int unsigned Q30_FRAC    = 30;
  localparam int unsigned WIDEN_SHIFT = 17;
  localparam int unsigned SINE_FRAC   = 15;

  // Angle folding limits, Q3.13
  localparam logic signed [ANGLE_W:0] PI_Q13      = 17'sd25736;
  localparam logic signed [ANGLE_W:0] HALF_PI_Q13 = 17'sd12868;

  localparam logic [T_W-1:0]      ONE_Q30  = 31'h4000_0000;
  localparam logic [SINE_W-2:0]   SINE_MAX = '1;

  // Horner divisors 110, 72, 42, 20, 6 as exact reciprocals:
  // floor(p / d) == (p * ceil(2^(32+l) / d)) >> (32+l) for any 32-bit p
  localparam int unsigned NUM_TERMS = 5;
  localparam int unsigned TERM_SHIFT [NUM_TERMS] = '{39, 39, 38, 37, 35};
  localparam logic [RECIP_W-1:0] TERM_RECIP [NUM_TERMS] = '{
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 35) + 64'd5) / 64'd6)
  };

  localparam logic signed [COEF_W-1:0] COEF_RESET = 16'sd4096;

  // Pipeline depths
  localparam int unsigned SINE_LATENCY   = 2 * NUM_TERMS + 4;
  localparam int unsigned TORQUE_LATENCY = 3;
  localparam int unsigned LATENCY        = SINE_LATENCY + TORQUE_LATENCY;

  typedef struct packed {
    logic signed [VEL_W-1:0] shoulder;
    logic signed [VEL_W-1:0] elbow;
  } vel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] c11;
    logic signed [OUT_W-1:0] c12;
    logic signed [OUT_W-1:0] c21;
    logic signed [OUT_W-1:0] tau_shoulder;
    logic signed [OUT_W-1:0] tau_elbow;
  } coriolis_t;

endpackage

### hw/rtl/ctk_sine.sv
// Pipelined fixed-point sine of the elbow angle (Taylor series in Horner form).
module ctk_sine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [ctk_pkg::ANGLE_W-1:0]  angle_i,
  input  ctk_pkg::vel_t                       vel_i,
  output logic                                valid_o,
  output logic signed [ctk_pkg::SINE_W-1:0]   sine_o,
  output ctk_pkg::vel_t                       vel_o
);

  localparam int unsigned N      = ctk_pkg::NUM_TERMS;
  localparam int unsigned A_W    = ctk_pkg::X2_W + ctk_pkg::T_W;
  localparam int unsigned MT_W   = ctk_pkg::MAG_W + ctk_pkg::T_W;
  localparam int unsigned MT_SHIFT = ctk_pkg::Q30_FRAC - ctk_pkg::WIDEN_SHIFT;
  localparam int unsigned RND_SHIFT = ctk_pkg::Q30_FRAC - ctk_pkg::SINE_FRAC;
  localparam int unsigned S_W    = 32;
  localparam int unsigned RND_W  = S_W - RND_SHIFT;

  typedef struct packed {
    logic [ctk_pkg::MAG_W-1:0] mag;
    logic                      neg;
    ctk_pkg::vel_t             vel;
  } side_t;

  // Fold the angle into [-pi/2, pi/2] and split off the sign
  logic signed [ctk_pkg::ANGLE_W:0] ang_ext;
  logic signed [ctk_pkg::ANGLE_W:0] fold_ang;
  logic                             fold_neg;
  logic [ctk_pkg::MAG_W-1:0]        fold_mag;

  always_comb begin
    ang_ext = (ctk_pkg::ANGLE_W + 1)'(angle_i);
    if (ang_ext > ctk_pkg::HALF_PI_Q13) begin
      fold_ang = ctk_pkg::PI_Q13 - ang_ext;
    end else if (ang_ext < -ctk_pkg::HALF_PI_Q13) begin
      fold_ang = -ctk_pkg::PI_Q13 - ang_ext;
    end else begin
      fold_ang = ang_ext;
    end
    fold_neg = fold_ang[ctk_pkg::ANGLE_W];
    fold_mag = ctk_pkg::MAG_W'(fold_neg ? -fold_ang : fold_ang);
  end

  logic  f_valid_q;
  side_t f_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    f_side_q <= '{mag: fold_mag, neg: fold_neg, vel: vel_i};
  end

  // Inter-step registers; index 0 holds x squared, index g+1 follows step g
  logic                       sx_valid_q [N+1];
  side_t                      sx_side_q  [N+1];
  logic [ctk_pkg::X2_W-1:0]   sx_x2_q    [N+1];
  logic [ctk_pkg::PROD_W-1:0] prod_q     [N];
  logic [ctk_pkg::T_W-1:0]    t_w        [N+1];
  logic [2*ctk_pkg::MAG_W-1:0] sq_w;

  // Square the magnitude: x2 = mag^2 in Q2.30
  assign sq_w = (2 * ctk_pkg::MAG_W)'(f_side_q.mag) * (2 * ctk_pkg::MAG_W)'(f_side_q.mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_valid_q[0] <= 1'b0;
    end else begin
      sx_valid_q[0] <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_side_q[0] <= f_side_q;
    sx_x2_q[0]   <= ctk_pkg::X2_W'({sq_w, 4'b0000});
  end

  assign t_w[0] = ctk_pkg::ONE_Q30;

  // One Horner step per pair of stages: multiply by x2, then by the reciprocal
  for (genvar g = 0; g < N; g++) begin : g_term
    logic                     a_valid_q;
    side_t                    a_side_q;
    logic [ctk_pkg::X2_W-1:0] a_x2_q;
    logic [ctk_pkg::P_W-1:0]  a_p_q;
    logic [A_W-1:0]           a_full;

    assign a_full = A_W'(sx_x2_q[g]) * A_W'(t_w[g]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_valid_q         <= 1'b0;
        sx_valid_q[g + 1] <= 1'b0;
      end else begin
        a_valid_q         <= sx_valid_q[g];
        sx_valid_q[g + 1] <= a_valid_q;
      end
    end

    always_ff @(posedge clk_i) begin
      a_side_q          <= sx_side_q[g];
      a_x2_q            <= sx_x2_q[g];
      a_p_q             <= ctk_pkg::P_W'(a_full >> ctk_pkg::Q30_FRAC);
      sx_side_q[g + 1]  <= a_side_q;
      sx_x2_q[g + 1]    <= a_x2_q;
      prod_q[g]         <= ctk_pkg::PROD_W'(a_p_q) * ctk_pkg::PROD_W'(ctk_pkg::TERM_RECIP[g]);
    end

    // Quotient stays below 2^30, so the next term is never negative
    assign t_w[g + 1] = ctk_pkg::ONE_Q30
                        - ctk_pkg::T_W'(prod_q[g] >> ctk_pkg::TERM_SHIFT[g]);
  end

  // Final multiply by x
  logic            s_valid_q;
  side_t           s_side_q;
  logic [MT_W-1:0] s_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= sx_valid_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    s_side_q <= sx_side_q[N];
    s_prod_q <= MT_W'(sx_side_q[N].mag) * MT_W'(t_w[N]);
  end

  // Round half up to Q1.15, cap, and restore the sign
  logic [S_W-1:0]                 s_val;
  logic [RND_W-1:0]               s_rnd;
  logic [ctk_pkg::SINE_W-2:0]     s_cap;
  logic signed [ctk_pkg::SINE_W-1:0] sine_d;

  always_comb begin
    s_val  = S_W'(s_prod_q >> MT_SHIFT);
    s_rnd  = RND_W'((s_val + (S_W'(1) << (RND_SHIFT - 1))) >> RND_SHIFT);
    s_cap  = (s_rnd > RND_W'(ctk_pkg::SINE_MAX)) ? ctk_pkg::SINE_MAX
                                                 : (ctk_pkg::SINE_W - 1)'(s_rnd);
    sine_d = s_side_q.neg ? -(ctk_pkg::SINE_W'(s_cap)) : ctk_pkg::SINE_W'(s_cap);
  end

  logic                              r_valid_q;
  logic signed [ctk_pkg::SINE_W-1:0] r_sine_q;
  ctk_pkg::vel_t                     r_vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_sine_q <= sine_d;
    r_vel_q  <= s_side_q.vel;
  end

  assign valid_o = r_valid_q;
  assign sine_o  = r_sine_q;
  assign vel_o   = r_vel_q;

  // Check valid travels with the data through every stage
  a_valid_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, ctk_pkg::SINE_LATENCY))
    else $error("sine result without a matching input");

  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(valid_i && (angle_i == '0), ctk_pkg::SINE_LATENCY) |-> sine_o == '0)
    else $error("sine of zero angle is not zero");

endmodule

### hw/rtl/ctk_torque.sv
// Coriolis entries and velocity torques from the sine, velocities and coefficient.
module ctk_torque (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [ctk_pkg::SINE_W-1:0]  sine_i,
  input  ctk_pkg::vel_t                      vel_i,
  input  logic signed [ctk_pkg::COEF_W-1:0]  coef_i,
  output logic                               valid_o,
  output ctk_pkg::coriolis_t                 result_o
);

  localparam int unsigned H_W     = 32;
  localparam int unsigned VV_W    = 2 * ctk_pkg::VEL_W;
  localparam int unsigned VS_W    = ctk_pkg::VEL_W + 1;
  localparam int unsigned W1_W    = VV_W + 1;
  localparam int unsigned C11_W   = H_W + ctk_pkg::VEL_W;
  localparam int unsigned C12_W   = H_W + VS_W;
  localparam int unsigned TAU1_W  = H_W + W1_W;
  localparam int unsigned TAU2_W  = H_W + VV_W;
  localparam int unsigned WIDE_W  = TAU1_W;
  localparam int unsigned C_SHIFT   = 19;
  localparam int unsigned TAU_SHIFT = 27;

  // Round half up by sh bits, then clamp to the output range
  function automatic logic signed [ctk_pkg::OUT_W-1:0] round_sat(
    input logic signed [WIDE_W-1:0] v,
    input int unsigned              sh
  );
    logic signed [WIDE_W-1:0] half;
    logic signed [WIDE_W-1:0] r;
    half = '0;
    half[sh - 1] = 1'b1;
    r = (v + half) >>> sh;
    if ((r[WIDE_W-1:ctk_pkg::OUT_W-1] == '0) || (r[WIDE_W-1:ctk_pkg::OUT_W-1] == '1)) begin
      round_sat = r[ctk_pkg::OUT_W-1:0];
    end else if (r[WIDE_W-1]) begin
      round_sat = {1'b1, {(ctk_pkg::OUT_W - 1){1'b0}}};
    end else begin
      round_sat = {1'b0, {(ctk_pkg::OUT_W - 1){1'b1}}};
    end
  endfunction

  // Stage H: h = -k*sin, velocity products
  logic                              h_valid_q;
  logic signed [H_W-1:0]             h_q;
  logic signed [VV_W-1:0]            p_cross_q;
  logic signed [VV_W-1:0]            p_ee_q;
  logic signed [VV_W-1:0]            p_ss_q;
  logic signed [VS_W-1:0]            vsum_q;
  logic signed [ctk_pkg::VEL_W-1:0]  v1_q;
  logic signed [ctk_pkg::VEL_W-1:0]  v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
    end else begin
      h_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q       <= -(H_W'(coef_i) * H_W'(sine_i));
    p_cross_q <= VV_W'(vel_i.shoulder) * VV_W'(vel_i.elbow);
    p_ee_q    <= VV_W'(vel_i.elbow) * VV_W'(vel_i.elbow);
    p_ss_q    <= VV_W'(vel_i.shoulder) * VV_W'(vel_i.shoulder);
    vsum_q    <= VS_W'(vel_i.shoulder) + VS_W'(vel_i.elbow);
    v1_q      <= vel_i.shoulder;
    v2_q      <= vel_i.elbow;
  end

  // Stage M: multiply h into each entry; tau1 = h*(2*v1*v2 + v2^2), tau2 = -h*v1^2
  logic signed [W1_W-1:0]   w1;
  logic                     m_valid_q;
  logic signed [C11_W-1:0]  c11_q;
  logic signed [C12_W-1:0]  c12_q;
  logic signed [C12_W-1:0]  c21_q;
  logic signed [TAU1_W-1:0] tau1_q;
  logic signed [TAU2_W-1:0] tau2_q;

  assign w1 = (W1_W'(p_cross_q) <<< 1) + W1_W'(p_ee_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= h_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c11_q  <= C11_W'(h_q) * C11_W'(v2_q);
    c12_q  <= C12_W'(h_q) * C12_W'(vsum_q);
    c21_q  <= C12_W'(h_q) * (-C12_W'(v1_q));
    tau1_q <= TAU1_W'(h_q) * TAU1_W'(w1);
    tau2_q <= TAU2_W'(h_q) * (-TAU2_W'(p_ss_q));
  end

  // Stage O: round and saturate to Q16.16
  logic               o_valid_q;
  ctk_pkg::coriolis_t o_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_res_q.c11          <= round_sat(WIDE_W'(c11_q), C_SHIFT);
    o_res_q.c12          <= round_sat(WIDE_W'(c12_q), C_SHIFT);
    o_res_q.c21          <= round_sat(WIDE_W'(c21_q), C_SHIFT);
    o_res_q.tau_shoulder <= round_sat(WIDE_W'(tau1_q), TAU_SHIFT);
    o_res_q.tau_elbow    <= round_sat(WIDE_W'(tau2_q), TAU_SHIFT);
  end

  assign valid_o  = o_valid_q;
  assign result_o = o_res_q;

  a_valid_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, ctk_pkg::TORQUE_LATENCY))
    else $error("torque result without a matching input");

  a_zero_sine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(valid_i && (sine_i == '0), ctk_pkg::TORQUE_LATENCY)
    |-> result_o == '0)
    else $error("nonzero Coriolis terms for zero sine");

endmodule

### hw/rtl/coriolis_torque_two_link_arm_top.sv
// Top level of the two-link arm Coriolis matrix and torque pipeline.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  command  | start, busy (always 0)  | elbow_angle_i, shoulder/elbow_velocity_i
//  result   | done_o, one-cycle pulse | c_row1_col1_o .. c_row2_col1_o, torque_*_o
//  config   | cfg_valid_i, cfg_ready_o| cfg_data_i (inertia coefficient, Q4.12)
//
// A command transfer is taken every cycle; its result appears on done_o
// after the sine pipeline (fold, square, five Horner steps of two
// multiplier stages each, final multiply, rounding) and then the torque
// stages (the h product, the entry multipliers and rounding/saturation).
// Reset clears all valid bits and loads the coefficient with 1.0.
// Nothing stalls: the receiver takes every result, so busy stays low.
module coriolis_torque_two_link_arm_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ctk_pkg::ANGLE_W-1:0] elbow_angle_i,
  input  logic signed [ctk_pkg::VEL_W-1:0]   shoulder_velocity_i,
  input  logic signed [ctk_pkg::VEL_W-1:0]   elbow_velocity_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic signed [ctk_pkg::COEF_W-1:0]  cfg_data_i,
  output logic                               done_o,
  output logic signed [ctk_pkg::OUT_W-1:0]   c_row1_col1_o,
  output logic signed [ctk_pkg::OUT_W-1:0]   c_row1_col2_o,
  output logic signed [ctk_pkg::OUT_W-1:0]   c_row2_col1_o,
  output logic signed [ctk_pkg::OUT_W-1:0]   torque_shoulder_o,
  output logic signed [ctk_pkg::OUT_W-1:0]   torque_elbow_o
);

  // Hold the inertia coefficient; load it on a config transfer
  logic signed [ctk_pkg::COEF_W-1:0] coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= ctk_pkg::COEF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      coef_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // Sine pipeline carries the velocities alongside
  logic                              in_xfer;
  ctk_pkg::vel_t                     vel_in;
  logic                              sine_valid;
  logic signed [ctk_pkg::SINE_W-1:0] sine;
  ctk_pkg::vel_t                     sine_vel;
  ctk_pkg::coriolis_t                result;

  assign in_xfer = start && !busy;
  assign vel_in  = '{shoulder: shoulder_velocity_i, elbow: elbow_velocity_i};

  ctk_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_xfer),
    .angle_i (elbow_angle_i),
    .vel_i   (vel_in),
    .valid_o (sine_valid),
    .sine_o  (sine),
    .vel_o   (sine_vel)
  );

  ctk_torque u_torque (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sine_valid),
    .sine_i   (sine),
    .vel_i    (sine_vel),
    .coef_i   (coef_q),
    .valid_o  (done_o),
    .result_o (result)
  );

  assign c_row1_col1_o     = result.c11;
  assign c_row1_col2_o     = result.c12;
  assign c_row2_col1_o     = result.c21;
  assign torque_shoulder_o = result.tau_shoulder;
  assign torque_elbow_o    = result.tau_elbow;

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, ctk_pkg::LATENCY))
    else $error("result strobe without a command transfer");

endmodule

### bench/coriolis_torque_two_link_arm_top_tb.sv
// Self-checking bench for the two-link arm Coriolis matrix and torque pipeline.
`timescale 1ns / 100ps

module coriolis_torque_two_link_arm_top_tb;

  import ctk_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = LATENCY + 2;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam longint      OUT_MAX        = (longint'(1) <<< 31) - 1;
  localparam longint      OUT_MIN        = -(longint'(1) <<< 31);

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [VEL_W-1:0]   shoulder;
    logic signed [VEL_W-1:0]   elbow;
  } arm_sample_t;

  typedef enum logic [1:0] {OP_SAMPLE, OP_COEF, OP_DRAIN} op_kind_e;

  typedef struct {
    op_kind_e                 kind;
    arm_sample_t              sample;
    logic signed [COEF_W-1:0] coef;
    int unsigned              idle_pct;
  } stim_op_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [ANGLE_W-1:0] elbow_angle_i = '0;
  logic signed [VEL_W-1:0]   shoulder_velocity_i = '0;
  logic signed [VEL_W-1:0]   elbow_velocity_i = '0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic signed [COEF_W-1:0]  cfg_data_i = '0;
  logic                      done_o;
  logic signed [OUT_W-1:0]   c_row1_col1_o;
  logic signed [OUT_W-1:0]   c_row1_col2_o;
  logic signed [OUT_W-1:0]   c_row2_col1_o;
  logic signed [OUT_W-1:0]   torque_shoulder_o;
  logic signed [OUT_W-1:0]   torque_elbow_o;

  stim_op_t                 stim_ops[$];
  coriolis_t                expected_terms[$];
  logic signed [COEF_W-1:0] inertia_shadow = COEF_RESET;
  int unsigned              outstanding = 0;
  int unsigned              quiet_cycles = 0;
  int unsigned              result_count = 0;
  int unsigned              mismatch_count = 0;
  int unsigned              stall_cycles = 0;
  logic                     sender_idle = 1'b0;

  coriolis_torque_two_link_arm_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .elbow_angle_i      (elbow_angle_i),
    .shoulder_velocity_i(shoulder_velocity_i),
    .elbow_velocity_i   (elbow_velocity_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .done_o             (done_o),
    .c_row1_col1_o      (c_row1_col1_o),
    .c_row1_col2_o      (c_row1_col2_o),
    .c_row2_col1_o      (c_row2_col1_o),
    .torque_shoulder_o  (torque_shoulder_o),
    .torque_elbow_o     (torque_elbow_o)
  );

  always #6 clk_i = ~clk_i;

  // Sine of a Q3.13 elbow angle in Q1.15: fold to +-pi/2, then Taylor series in Horner form
  function automatic logic signed [SINE_W-1:0] elbow_sine_q15(logic signed [ANGLE_W-1:0] angle);
    longint folded, x, x2, t, s, divisor;
    int     i;
    folded = longint'(angle);
    if (folded > longint'(HALF_PI_Q13)) folded = longint'(PI_Q13) - folded;
    else if (folded < -longint'(HALF_PI_Q13)) folded = -longint'(PI_Q13) - folded;
    x = (folded < 0 ? -folded : folded) <<< WIDEN_SHIFT;
    x2 = (x * x) >>> Q30_FRAC;
    t = longint'(1) <<< Q30_FRAC;
    for (i = 0; i < 5; i++) begin
      case (i)
        0:       divisor = 110;
        1:       divisor = 72;
        2:       divisor = 42;
        3:       divisor = 20;
        default: divisor = 6;
      endcase
      t = (longint'(1) <<< Q30_FRAC) - ((x2 * t) >>> Q30_FRAC) / divisor;
    end
    s = (x * t) >>> Q30_FRAC;
    s = (s + (longint'(1) <<< (SINE_FRAC - 1))) >>> SINE_FRAC;
    if (s > 32767) s = 32767;
    return (folded < 0) ? SINE_W'(-s) : SINE_W'(s);
  endfunction

  // Round half up to Q16.16 and clamp to 32 bits
  function automatic logic signed [OUT_W-1:0] round_q16(longint v, int unsigned frac);
    longint r;
    r = (v + (longint'(1) <<< (frac - 1))) >>> frac;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return OUT_W'(r);
  endfunction

  // Coriolis entries and velocity torques for one sample
  function automatic coriolis_t coriolis_terms(arm_sample_t s, logic signed [COEF_W-1:0] k);
    longint    h, v1, v2, c11, c12, c21;
    coriolis_t r;
    v1  = longint'($signed(s.shoulder));
    v2  = longint'($signed(s.elbow));
    h   = -(longint'(k) * longint'(elbow_sine_q15(s.angle)));
    c11 = h * v2;
    c12 = h * (v1 + v2);
    c21 = -h * v1;
    r.c11          = round_q16(c11, 19);
    r.c12          = round_q16(c12, 19);
    r.c21          = round_q16(c21, 19);
    r.tau_shoulder = round_q16(c11 * v1 + c12 * v2, 27);
    r.tau_elbow    = round_q16(c21 * v1, 27);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic signed [OUT_W-1:0] got,
                             logic signed [OUT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                result_count, name, got, want));
  endtask

  function automatic void queue_sample(logic signed [ANGLE_W-1:0] a,
                                       logic signed [VEL_W-1:0] v1,
                                       logic signed [VEL_W-1:0] v2, int unsigned idle_pct);
    stim_op_t op;
    op.kind     = OP_SAMPLE;
    op.sample   = '{angle: a, shoulder: v1, elbow: v2};
    op.coef     = '0;
    op.idle_pct = idle_pct;
    stim_ops.push_back(op);
  endfunction

  function automatic void queue_coef(logic signed [COEF_W-1:0] k);
    stim_op_t op;
    op.kind     = OP_COEF;
    op.sample   = '0;
    op.coef     = k;
    op.idle_pct = 0;
    stim_ops.push_back(op);
  endfunction

  function automatic void queue_drain();
    stim_op_t op;
    op.kind     = OP_DRAIN;
    op.sample   = '0;
    op.coef     = '0;
    op.idle_pct = 0;
    stim_ops.push_back(op);
  endfunction

  // Mostly angles within +-pi, some across the whole 16-bit range, some at the fold points and range ends
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return ANGLE_W'(int'($urandom_range(2 * int'(PI_Q13))) - int'(PI_Q13));
    if (pick < 85) return ANGLE_W'($urandom);
    case ($urandom_range(5))
      0:       return ANGLE_W'(HALF_PI_Q13);
      1:       return ANGLE_W'(-HALF_PI_Q13);
      2:       return ANGLE_W'(PI_Q13);
      3:       return ANGLE_W'(-PI_Q13);
      4:       return 16'sh7FFF;
      default: return 16'sh8000;
    endcase
  endfunction

  function automatic logic signed [VEL_W-1:0] random_velocity();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return VEL_W'($urandom);
    if (pick < 85) return VEL_W'(int'($urandom_range(1024)) - 512);
    case ($urandom_range(4))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'sh0001;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Sender: pop pending operations; coefficient writes and drains wait for a quiet pipeline
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic start_nxt;
    logic cfg_nxt;
    if (!rst_ni) begin
      start               <= 1'b0;
      cfg_valid_i         <= 1'b0;
      cfg_data_i          <= '0;
      elbow_angle_i       <= '0;
      shoulder_velocity_i <= '0;
      elbow_velocity_i    <= '0;
      inertia_shadow      <= COEF_RESET;
      quiet_cycles        <= 0;
      sender_idle         <= 1'b0;
    end else begin
      // hold a request until its transfer
      start_nxt = start && busy;
      cfg_nxt   = cfg_valid_i && !cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) inertia_shadow <= cfg_data_i;
      if (outstanding == 0 && !start) begin
        if (quiet_cycles < SETTLE_CYCLES) quiet_cycles <= quiet_cycles + 1;
      end else begin
        quiet_cycles <= 0;
      end
      if (!start_nxt && !cfg_nxt && stim_ops.size() != 0) begin
        case (stim_ops[0].kind)
          OP_SAMPLE: begin
            if ($urandom_range(99) >= stim_ops[0].idle_pct) begin
              elbow_angle_i       <= stim_ops[0].sample.angle;
              shoulder_velocity_i <= stim_ops[0].sample.shoulder;
              elbow_velocity_i    <= stim_ops[0].sample.elbow;
              start_nxt = 1'b1;
              void'(stim_ops.pop_front());
            end
          end
          OP_COEF: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              cfg_data_i <= stim_ops[0].coef;
              cfg_nxt = 1'b1;
              void'(stim_ops.pop_front());
            end
          end
          default: begin
            if (quiet_cycles >= SETTLE_CYCLES) void'(stim_ops.pop_front());
          end
        endcase
      end
      start       <= start_nxt;
      cfg_valid_i <= cfg_nxt;
      sender_idle <= (stim_ops.size() == 0) && !start_nxt && !cfg_nxt;
    end
  end

  // Monitor: retire a result against the oldest expectation, then predict any new transfer
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    coriolis_t want;
    arm_sample_t taken;
    if (!rst_ni) begin
      outstanding <= 0;
    end else begin
      if (done_o) begin
        if (expected_terms.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
        end else begin
          want = expected_terms.pop_front();
          check_field("c_row1_col1", c_row1_col1_o, want.c11);
          check_field("c_row1_col2", c_row1_col2_o, want.c12);
          check_field("c_row2_col1", c_row2_col1_o, want.c21);
          check_field("torque_shoulder", torque_shoulder_o, want.tau_shoulder);
          check_field("torque_elbow", torque_elbow_o, want.tau_elbow);
        end
        result_count <= result_count + 1;
      end
      if (start && !busy) begin
        taken = '{angle: elbow_angle_i, shoulder: shoulder_velocity_i, elbow: elbow_velocity_i};
        expected_terms.push_back(coriolis_terms(taken, inertia_shadow));
      end
      outstanding <= expected_terms.size();
    end
  end

  // Watchdog: give up after a long stretch with no transfer on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n;

    // Directed: reset coefficient, fold points, out-of-range angles, velocity extremes
    queue_sample(16'sd0, 16'sd0, 16'sd0, 0);
    queue_sample(16'sd12868, 16'sh7FFF, 16'sh7FFF, 0);
    queue_sample(-16'sd12868, 16'sh8000, 16'sh8000, 0);
    queue_sample(16'sd25736, 16'sd256, 16'sd256, 0);
    queue_sample(-16'sd25736, -16'sd256, 16'sd512, 0);
    queue_sample(16'sh7FFF, 16'sh7FFF, 16'sh8000, 0);
    queue_sample(16'sh8000, 16'sh8000, 16'sh7FFF, 0);
    queue_sample(16'sd12867, 16'sd1000, -16'sd1000, 0);
    queue_sample(16'sd12869, -16'sd1, 16'sd1, 0);
    queue_sample(16'sd6434, 16'sd256, -16'sd256, 0);
    queue_sample(16'sd1, 16'sh7FFF, 16'sd0, 0);
    queue_sample(-16'sd1, 16'sd0, 16'sh7FFF, 0);
    queue_sample(-16'sd12869, 16'sd12345, -16'sd6789, 0);
    queue_sample(-16'sd6434, 16'sh8000, 16'sh8000, 0);

    // Coefficient extremes drive the torques into saturation
    for (n = 0; n < 2; n++) begin
      queue_coef(n == 0 ? 16'sh7FFF : 16'sh8000);
      queue_sample(16'sd12868, 16'sh7FFF, 16'sh7FFF, 0);
      queue_sample(-16'sd12868, 16'sh8000, 16'sh7FFF, 0);
      queue_sample(16'sd12868, 16'sh8000, 16'sh8000, 0);
      queue_sample(16'sd3000, 16'sd100, -16'sd200, 0);
    end

    // Random, light sender idling
    queue_coef(COEF_W'($urandom));
    for (n = 0; n < 230; n++) begin
      if (n % 60 == 59) queue_drain();
      queue_sample(random_angle(), random_velocity(), random_velocity(), 15);
    end

    // Random, heavy sender idling
    queue_coef(16'sh8000);
    for (n = 0; n < 230; n++) begin
      if (n % 60 == 59) queue_drain();
      queue_sample(random_angle(), random_velocity(), random_velocity(), 85);
    end

    // Random, back to back, stepping through several coefficients
    for (n = 0; n < 240; n++) begin
      if (n == 0) queue_coef(16'sh7FFF);
      if (n == 80) queue_coef(COEF_W'($urandom));
      if (n == 160) queue_coef(COEF_RESET);
      queue_sample(random_angle(), random_velocity(), random_velocity(), 0);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (!(sender_idle && outstanding == 0));
    repeat (LATENCY + 4) @(posedge clk_i);

    if (mismatch_count == 0 && expected_terms.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ctk_pkg.sv
hw/rtl/ctk_sine.sv
hw/rtl/ctk_torque.sv
hw/rtl/coriolis_torque_two_link_arm_top.sv
bench/coriolis_torque_two_link_arm_top_tb.sv
